// ----- hw/rtl/ofcc_pkg.sv -----
// Shared types, widths and constant tables of the optical flow color coder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ofcc_pkg;

	// Flow component width (signed Q15.8 at the default of 24 bits).
	localparam int FLOW_BITS = 24;

	// CORDIC datapath: operands are pre-scaled by 2^16 and grow by the CORDIC gain.
	localparam int CORDIC_STEPS = 14;
	localparam int CORD_W       = FLOW_BITS + 18;
	localparam int Z_W          = 17;
	localparam int ANG_W        = 15;
	localparam logic [ANG_W-1:0] Z_QUARTER = 15'd16384;

	// Magnitude datapath.
	localparam int SQ_W      = 2 * FLOW_BITS;
	localparam int RSQ_W     = 46;
	localparam int M_W       = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;
	localparam int RADIUS_W  = 23;
	localparam int ISQ_W     = 62;
	localparam int ISQ_STEPS = 31;
	localparam int NUM_W     = 39;
	localparam int DIV_STEPS = 17;
	localparam int RAD_W     = 17;

	// Pipeline bookkeeping: the angle waits for the magnitude path.
	localparam int ZDLY       = 34;
	localparam int LAST_STAGE = 52;

	// Color wheel.
	localparam int unsigned SEG_RY  = 15;
	localparam int unsigned SEG_YG  = 6;
	localparam int unsigned SEG_GC  = 4;
	localparam int unsigned SEG_CB  = 11;
	localparam int unsigned SEG_BM  = 13;
	localparam int unsigned SEG_MR  = 6;
	localparam int unsigned WHEEL_N = SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM + SEG_MR;
	localparam int unsigned FULL    = 255;
	localparam int COL_W = 24;
	localparam logic [COL_W-1:0] FULL_Q16 = 24'd255 << 16;
	localparam logic [39:0]      FULL_Q32 = 40'd255 << 32;

	// Register map (word index) and reset values.
	localparam logic [0:0] REG_MAX_RADIUS = 1'b0;
	localparam logic [RADIUS_W-1:0] MAX_RADIUS_RST = 23'd256;

	typedef struct packed {
		logic signed [FLOW_BITS-1:0] flow_x;
		logic signed [FLOW_BITS-1:0] flow_y;
		logic                        flow_valid;
	} flow_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_out_t;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic fv;
	} side_t;

	// Arc tangent of 2^-i in units of 2^-16 turn.
	function automatic logic [13:0] atan_turn(input int i);
		logic [13:0] a;
		unique case (i)
			0:       a = 14'd8192;
			1:       a = 14'd4836;
			2:       a = 14'd2555;
			3:       a = 14'd1297;
			4:       a = 14'd651;
			5:       a = 14'd326;
			6:       a = 14'd163;
			7:       a = 14'd81;
			8:       a = 14'd41;
			9:       a = 14'd20;
			10:      a = 14'd10;
			11:      a = 14'd5;
			12:      a = 14'd3;
			13:      a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

	// Color wheel entry k as {red, green, blue}.
	function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
		int unsigned kk;
		int unsigned i;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		kk = k;
		i = 0;
		r = 0;
		g = 0;
		b = 0;
		if (kk < SEG_RY) begin
			r = FULL; g = FULL * kk / SEG_RY; b = 0;
		end else if (kk < SEG_RY + SEG_YG) begin
			i = kk - SEG_RY;
			r = FULL - FULL * i / SEG_YG; g = FULL; b = 0;
		end else if (kk < SEG_RY + SEG_YG + SEG_GC) begin
			i = kk - (SEG_RY + SEG_YG);
			r = 0; g = FULL; b = FULL * i / SEG_GC;
		end else if (kk < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
			i = kk - (SEG_RY + SEG_YG + SEG_GC);
			r = 0; g = FULL - FULL * i / SEG_CB; b = FULL;
		end else if (kk < SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM) begin
			i = kk - (SEG_RY + SEG_YG + SEG_GC + SEG_CB);
			r = FULL * i / SEG_BM; g = 0; b = FULL;
		end else begin
			i = kk - (SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM);
			if (i >= SEG_MR)
				i = SEG_MR - 1;
			r = FULL; g = 0; b = FULL - FULL * i / SEG_MR;
		end
		return {8'(r), 8'(g), 8'(b)};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ofcc_cordic_cell.sv -----
// One vectoring CORDIC iteration with its output register.
// Depends on ofcc_pkg for widths and the arc tangent table.
`default_nettype none

module ofcc_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [ofcc_pkg::CORD_W-1:0] x_in,
	input  logic signed [ofcc_pkg::CORD_W-1:0] y_in,
	input  logic signed [ofcc_pkg::Z_W-1:0]    z_in,
	output logic signed [ofcc_pkg::CORD_W-1:0] x_q,
	output logic signed [ofcc_pkg::CORD_W-1:0] y_q,
	output logic signed [ofcc_pkg::Z_W-1:0]    z_q
);

	logic signed [ofcc_pkg::CORD_W-1:0] xs;
	logic signed [ofcc_pkg::CORD_W-1:0] ys;
	logic signed [ofcc_pkg::Z_W-1:0]    at;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign at = ofcc_pkg::Z_W'(ofcc_pkg::atan_turn(STEP));

	// Rotate toward the x axis; the sign of y picks the direction.
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + at;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - at;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ofcc_sqrt_cell.sv -----
// One digit step of the restoring integer square root, registered.
// Depends on ofcc_pkg for widths.
`default_nettype none

module ofcc_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [ofcc_pkg::ISQ_W-1:0]    v_in,
	input  logic [ofcc_pkg::ISQ_W-1:0]    r_in,
	output logic [ofcc_pkg::ISQ_W-1:0]    v_q,
	output logic [ofcc_pkg::ISQ_W-1:0]    r_q
);

	localparam logic [ofcc_pkg::ISQ_W-1:0] BIT =
		ofcc_pkg::ISQ_W'(1) << (ofcc_pkg::ISQ_W - 2 - 2 * STEP);

	logic [ofcc_pkg::ISQ_W:0] trial;

	assign trial = {1'b0, r_in} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, v_in} >= trial) begin
				v_q <= v_in - trial[ofcc_pkg::ISQ_W-1:0];
				r_q <= (r_in >> 1) + BIT;
			end else begin
				v_q <= v_in;
				r_q <= r_in >> 1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ofcc_div_cell.sv -----
// One quotient bit of the restoring divider that scales the flow length.
// Depends on ofcc_pkg for widths.
`default_nettype none

module ofcc_div_cell #(
	parameter int STEP = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ofcc_pkg::RADIUS_W-1:0]   den,
	input  logic [ofcc_pkg::NUM_W-1:0]      rem_in,
	input  logic [ofcc_pkg::RAD_W-1:0]      q_in,
	output logic [ofcc_pkg::NUM_W-1:0]      rem_q,
	output logic [ofcc_pkg::RAD_W-1:0]      q_q
);

	localparam int QB = ofcc_pkg::DIV_STEPS - 1 - STEP;

	logic [ofcc_pkg::NUM_W:0] dsh;

	assign dsh = (ofcc_pkg::NUM_W + 1)'(den) << QB;

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, rem_in} >= dsh) begin
				rem_q <= rem_in - dsh[ofcc_pkg::NUM_W-1:0];
				q_q   <= q_in | (ofcc_pkg::RAD_W'(1) << QB);
			end else begin
				rem_q <= rem_in;
				q_q   <= q_in;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/optical_flow_color_coder_top.sv -----
// Top level of the optical flow color coder: flow vector in, RGB pixel out.
// Depends on ofcc_pkg and the cells ofcc_cordic_cell, ofcc_sqrt_cell, ofcc_div_cell.
//
// Usage: each input transaction on in_valid/in_ready carries one flow vector
// (flow_x, flow_y, flow_valid); each output transaction on out_valid/out_ready
// carries one RGB pixel, 8 bits per channel, in the same order. The block is a fixed
// pipeline of 52 stages built from rows of cells: 14 CORDIC cells find the
// direction, 31 square root cells and 17 divider cells find the length relative
// to max_radius, and a few stages look up and blend the color wheel.
// Throughput is one transaction per cycle while the output buffer is not full, set
// by the one-step-per-cell chains.
// The pipeline ends in a two-entry output buffer. When the receiver stalls, a
// finished pixel waits there while the pipeline keeps accepting; only when
// both entries are full does the whole pipeline hold and in_ready drop.
// in_ready depends on registered state only. Reset clears all valid bits and the
// buffer and sets max_radius to 256. max_radius is written through the APB port at
// address 0; the user must write it only while idle, which the block itself does
// not enforce. A zero value acts as one. Reads return the register.
`default_nettype none

module optical_flow_color_coder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ofcc_pkg::flow_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ofcc_pkg::pix_out_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int FB   = ofcc_pkg::FLOW_BITS;
	localparam int LAST = ofcc_pkg::LAST_STAGE;
	localparam int ZD   = ofcc_pkg::ZDLY;
	localparam int NC   = ofcc_pkg::CORDIC_STEPS;
	localparam int NS   = ofcc_pkg::ISQ_STEPS;
	localparam int ND   = ofcc_pkg::DIV_STEPS;

	// ---------------------------------------------------------------
	// Configuration register. The effective radius and its square are
	// kept in registers so the compare and divider see plain flops.
	// ---------------------------------------------------------------
	logic [ofcc_pkg::RADIUS_W-1:0] max_radius_q;
	logic [ofcc_pkg::RADIUS_W-1:0] reff_q;
	logic [ofcc_pkg::RSQ_W-1:0]    rsq_q;
	logic [ofcc_pkg::RADIUS_W-1:0] reff_c;
	logic [ofcc_pkg::RSQ_W-1:0]    rsq_c;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2:2] == ofcc_pkg::REG_MAX_RADIUS);
	assign prdata = (paddr[2:2] == ofcc_pkg::REG_MAX_RADIUS) ?
		{9'b0, max_radius_q} : 32'b0;

	assign reff_c = (max_radius_q == '0) ? ofcc_pkg::RADIUS_W'(1) : max_radius_q;
	assign rsq_c  = ofcc_pkg::RSQ_W'(reff_c) * ofcc_pkg::RSQ_W'(reff_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_radius_q <= ofcc_pkg::MAX_RADIUS_RST;
			reff_q       <= ofcc_pkg::MAX_RADIUS_RST;
			rsq_q        <= ofcc_pkg::RSQ_W'(ofcc_pkg::MAX_RADIUS_RST) *
				ofcc_pkg::RSQ_W'(ofcc_pkg::MAX_RADIUS_RST);
		end else begin
			if (cfg_wr)
				max_radius_q <= pwdata[ofcc_pkg::RADIUS_W-1:0];
			reff_q <= reff_c;
			rsq_q  <= rsq_c;
		end
	end

	// ---------------------------------------------------------------
	// Flow control: the whole pipeline advances unless the output buffer
	// is full. Bubbles move along with the data.
	// ---------------------------------------------------------------
	logic       en;
	logic [1:0] cnt_q;
	logic [LAST:1] vld_q;

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAST-1:1], in_valid};
	end

	// Side information that rides along with every stage.
	ofcc_pkg::side_t side_q [1:LAST];
	logic            ins_q  [3:LAST];

	// ---------------------------------------------------------------
	// Stage 1: absolute values and quadrant.
	// ---------------------------------------------------------------
	logic [FB-1:0] ax_s1;
	logic [FB-1:0] ay_s1;
	logic [FB-1:0] ax_c;
	logic [FB-1:0] ay_c;

	assign ax_c = in_data.flow_x[FB-1] ? (~in_data.flow_x + FB'(1)) : in_data.flow_x;
	assign ay_c = in_data.flow_y[FB-1] ? (~in_data.flow_y + FB'(1)) : in_data.flow_y;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax_c;
			ay_s1 <= ay_c;
			side_q[1] <= '{xneg: in_data.flow_x[FB-1], yneg: in_data.flow_y[FB-1],
				fv: in_data.flow_valid};
			for (int k = 2; k <= LAST; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	// ---------------------------------------------------------------
	// Direction: a row of CORDIC cells, stages 2 to 15.
	// ---------------------------------------------------------------
	logic signed [ofcc_pkg::CORD_W-1:0] cx [0:NC];
	logic signed [ofcc_pkg::CORD_W-1:0] cy [0:NC];
	logic signed [ofcc_pkg::Z_W-1:0]    cz [0:NC];

	assign cx[0] = {2'b00, ax_s1, 16'b0};
	assign cy[0] = {2'b00, ay_s1, 16'b0};
	assign cz[0] = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		ofcc_cordic_cell #(.STEP(i)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (cx[i]),
			.y_in (cy[i]),
			.z_in (cz[i]),
			.x_q  (cx[i+1]),
			.y_q  (cy[i+1]),
			.z_q  (cz[i+1])
		);
	end

	// First quadrant angle is clamped, then waits for the length.
	logic [ofcc_pkg::ANG_W-1:0] zc;
	logic [ofcc_pkg::ANG_W-1:0] zd_q [0:ZD-1];

	always_comb begin
		if (cz[NC] < 0)
			zc = '0;
		else if (cz[NC] > signed'({2'b00, ofcc_pkg::Z_QUARTER}))
			zc = ofcc_pkg::Z_QUARTER;
		else
			zc = cz[NC][ofcc_pkg::ANG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zd_q[0] <= zc;
			for (int k = 1; k < ZD; k++)
				zd_q[k] <= zd_q[k-1];
		end
	end

	// ---------------------------------------------------------------
	// Length: squares (stage 2), sum and radius compare (stage 3).
	// ---------------------------------------------------------------
	logic [ofcc_pkg::SQ_W-1:0]  sqx_s2;
	logic [ofcc_pkg::SQ_W-1:0]  sqy_s2;
	logic [ofcc_pkg::M_W-1:0]   m_c;
	logic [ofcc_pkg::ISQ_W-1:0] v_s3;

	assign m_c = ofcc_pkg::M_W'(sqx_s2) + ofcc_pkg::M_W'(sqy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= ofcc_pkg::SQ_W'(ax_s1) * ofcc_pkg::SQ_W'(ax_s1);
			sqy_s2   <= ofcc_pkg::SQ_W'(ay_s1) * ofcc_pkg::SQ_W'(ay_s1);
			ins_q[3] <= (m_c <= ofcc_pkg::M_W'(rsq_q));
			for (int k = 4; k <= LAST; k++)
				ins_q[k] <= ins_q[k-1];
			// Only lengths inside the radius use the root, and those fit 46 bits.
			v_s3     <= {m_c[ofcc_pkg::RSQ_W-1:0], 16'b0};
		end
	end

	// Square root cells, stages 4 to 34.
	logic [ofcc_pkg::ISQ_W-1:0] sv [0:NS];
	logic [ofcc_pkg::ISQ_W-1:0] sr [0:NS];

	assign sv[0] = v_s3;
	assign sr[0] = '0;

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		ofcc_sqrt_cell #(.STEP(j)) u_cell (
			.clk  (clk),
			.en   (en),
			.v_in (sv[j]),
			.r_in (sr[j]),
			.v_q  (sv[j+1]),
			.r_q  (sr[j+1])
		);
	end

	// Divider cells, stages 35 to 51: rad = root * 256 / radius.
	logic [ofcc_pkg::NUM_W-1:0] drem [0:ND];
	logic [ofcc_pkg::RAD_W-1:0] dq   [0:ND];

	assign drem[0] = {sr[NS][ofcc_pkg::NUM_W-9:0], 8'b0};
	assign dq[0]   = '0;

	for (genvar j = 0; j < ND; j++) begin : g_div
		ofcc_div_cell #(.STEP(j)) u_cell (
			.clk    (clk),
			.en     (en),
			.den    (reff_q),
			.rem_in (drem[j]),
			.q_in   (dq[j]),
			.rem_q  (drem[j+1]),
			.q_q    (dq[j+1])
		);
	end

	// ---------------------------------------------------------------
	// Stage 50: fold the angle into its quadrant and find the wheel slot.
	// ---------------------------------------------------------------
	logic [16:0] phi_c;
	logic [21:0] p_c;
	logic [5:0]  k0_c;
	logic [5:0]  k0_s50;
	logic [5:0]  k1_s50;
	logic [15:0] f_s50;

	always_comb begin
		if (!side_q[LAST-3].xneg && !side_q[LAST-3].yneg)
			phi_c = 17'(zd_q[ZD-1]);
		else if (side_q[LAST-3].xneg && !side_q[LAST-3].yneg)
			phi_c = 17'd32768 - 17'(zd_q[ZD-1]);
		else if (side_q[LAST-3].xneg)
			phi_c = 17'd32768 + 17'(zd_q[ZD-1]);
		else
			phi_c = 17'd65536 - 17'(zd_q[ZD-1]);
		p_c  = 22'(phi_c[15:0]) * 22'(ofcc_pkg::WHEEL_N);
		k0_c = p_c[21:16];
		if (k0_c > 6'(ofcc_pkg::WHEEL_N - 1))
			k0_c = 6'(ofcc_pkg::WHEEL_N - 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k0_s50 <= k0_c;
			k1_s50 <= (k0_c == 6'(ofcc_pkg::WHEEL_N - 1)) ? 6'd0 : k0_c + 6'd1;
			f_s50  <= p_c[15:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 51: look up both neighbors and interpolate each channel.
	// The wheel is a constant table, filled from the package function.
	// ---------------------------------------------------------------
	logic [23:0] wheel_rom [0:ofcc_pkg::WHEEL_N-1];
	logic [23:0] w0;
	logic [23:0] w1;
	logic [16:0] fi;
	logic [ofcc_pkg::COL_W-1:0] c_s51 [0:2];

	for (genvar g = 0; g < ofcc_pkg::WHEEL_N; g++) begin : g_wheel
		assign wheel_rom[g] = ofcc_pkg::wheel_rgb(6'(g));
	end

	assign w0 = wheel_rom[k0_s50];
	assign w1 = wheel_rom[k1_s50];
	assign fi = 17'h10000 - {1'b0, f_s50};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++)
				c_s51[ch] <= ofcc_pkg::COL_W'(fi) * ofcc_pkg::COL_W'(w0[23-8*ch -: 8]) +
					ofcc_pkg::COL_W'(f_s50) * ofcc_pkg::COL_W'(w1[23-8*ch -: 8]);
		end
	end

	// ---------------------------------------------------------------
	// Stage 52: blend toward white inside the radius, or dim to 3/4; invalid flow gives black.
	// ---------------------------------------------------------------
	logic [40:0] prod_s52  [0:2];
	logic [7:0]  outer_s52 [0:2];
	logic [25:0] tri_c     [0:2];

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			tri_c[ch] = 26'(c_s51[ch]) * 26'd3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				prod_s52[ch]  <= 41'(dq[ND]) * 41'(ofcc_pkg::FULL_Q16 - c_s51[ch]);
				outer_s52[ch] <= tri_c[ch][25:18];
			end
		end
	end

	logic [39:0] diff_c [0:2];
	logic [7:0]  chan_c [0:2];
	ofcc_pkg::pix_out_t pix_c;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			diff_c[ch] = ofcc_pkg::FULL_Q32 - prod_s52[ch][39:0];
			if (!side_q[LAST].fv)
				chan_c[ch] = 8'd0;
			else if (ins_q[LAST])
				chan_c[ch] = diff_c[ch][39:32];
			else
				chan_c[ch] = outer_s52[ch];
		end
		pix_c = '{red: chan_c[0], green: chan_c[1], blue: chan_c[2]};
	end

	// ---------------------------------------------------------------
	// Two-entry output buffer.
	// ---------------------------------------------------------------
	ofcc_pkg::pix_out_t e0_q;
	ofcc_pkg::pix_out_t e1_q;
	logic push;
	logic pop;

	assign push      = en && vld_q[LAST];
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
	end

	always_ff @(posedge clk) begin
		if (push && (pop || cnt_q == 2'd0))
			e0_q <= pix_c;
		else if (pop && cnt_q == 2'd2)
			e0_q <= e1_q;
		if (push && !pop && cnt_q == 2'd1)
			e1_q <= pix_c;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ofcc_checker.sv -----
// Port-level checks of the optical flow color coder, bound to its top level.
// Depends on ofcc_pkg for the pixel type.
`default_nettype none

module ofcc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ofcc_pkg::pix_out_t out_data
);

	// Input backpressure only arises from a full output buffer.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low without a waiting transaction");

	// A full buffer stays full until a transaction leaves.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && !out_ready) |=> !in_ready)
		else $error("in_ready rose without an output transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output transaction changed while stalled");

endmodule

bind optical_flow_color_coder_top ofcc_checker u_ofcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ----- dv/ofcc_checker.sv -----
// Checker for the optical flow color coder: predicts each pixel from accepted flow vectors
// and compares it with the output transactions. Depends on ofcc_pkg only.
`default_nettype none

module ofcc_scoreboard (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire ofcc_pkg::flow_in_t in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire ofcc_pkg::pix_out_t out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	output int                      error_count,
	output int                      pending
);

	localparam longint ARC_STEP [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
		20, 10, 5, 3, 1};
	localparam longint unsigned SPOKES = 55;

	logic [ofcc_pkg::RADIUS_W-1:0] radius_q;
	ofcc_pkg::pix_out_t pixel_q[$];
	int mismatches;

	// Wheel entry k, channel ch (0 red, 1 green, 2 blue), as an 8-bit level.
	function automatic longint unsigned spoke_level(longint unsigned k, int ch);
		longint unsigned r, g, b, i;
		if (k < 15) begin
			r = 255; g = 255 * k / 15; b = 0;
		end else if (k < 21) begin
			i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
		end else if (k < 25) begin
			i = k - 21; r = 0; g = 255; b = 255 * i / 4;
		end else if (k < 36) begin
			i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
		end else if (k < 49) begin
			i = k - 36; r = 255 * i / 13; g = 0; b = 255;
		end else begin
			i = k - 49;
			if (i > 5)
				i = 5;
			r = 255; g = 0; b = 255 - 255 * i / 6;
		end
		return (ch == 0) ? r : ((ch == 1) ? g : b);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic ofcc_pkg::pix_out_t flow_color(ofcc_pkg::flow_in_t t,
		logic [ofcc_pkg::RADIUS_W-1:0] radius);
		longint sx, sy, ax, ay, cx, cy, nx, z, phi;
		longint unsigned p, k0, k1, frac, rr, mag, lim, rad, c, v;
		logic [7:0] lvl[3];
		ofcc_pkg::pix_out_t px;
		if (!t.flow_valid)
			return '0;
		sx = longint'(t.flow_x);
		sy = longint'(t.flow_y);
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		cx = ax * 65536;
		cy = ay * 65536;
		z = 0;
		for (int i = 0; i < 14; i++) begin
			if (cy > 0) begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z = z + ARC_STEP[i];
			end else begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z = z - ARC_STEP[i];
			end
			cx = nx;
		end
		if (z < 0)
			z = 0;
		if (z > 16384)
			z = 16384;
		if (sx >= 0 && sy >= 0)
			phi = z;
		else if (sx < 0 && sy >= 0)
			phi = 32768 - z;
		else if (sx < 0)
			phi = 32768 + z;
		else
			phi = 65536 - z;
		p = longint'(phi & 64'hFFFF) * SPOKES;
		k0 = p >> 16;
		if (k0 >= SPOKES)
			k0 = SPOKES - 1;
		k1 = (k0 + 1) % SPOKES;
		frac = p & 64'hFFFF;
		rr = (radius == 0) ? 1 : radius;
		mag = ax * ax + ay * ay;
		lim = rr * rr;
		rad = 0;
		if (mag <= lim) begin
			rad = (int_sqrt(mag << 16) << 8) / rr;
			if (rad > 65536)
				rad = 65536;
		end
		for (int ch = 0; ch < 3; ch++) begin
			c = (65536 - frac) * spoke_level(k0, ch) + frac * spoke_level(k1, ch);
			if (mag <= lim)
				v = ((64'd255 << 32) - rad * (64'd255 * 65536 - c)) >> 32;
			else
				v = (3 * c) >> 18;
			lvl[ch] = v[7:0];
		end
		px.red = lvl[0];
		px.green = lvl[1];
		px.blue = lvl[2];
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ofcc_pkg::MAX_RADIUS_RST;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == ofcc_pkg::REG_MAX_RADIUS) begin
			radius_q <= pwdata[ofcc_pkg::RADIUS_W-1:0];
		end
	end

	always @(posedge clk) begin
		ofcc_pkg::pix_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				pixel_q = {pixel_q, flow_color(in_data, radius_q)};
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel %h with nothing pending", out_data);
				end else begin
					want = pixel_q.pop_front();
					if (want.red !== out_data.red || want.green !== out_data.green ||
					    want.blue !== out_data.blue) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
								want.red, want.green, want.blue,
								out_data.red, out_data.green, out_data.blue);
					end
				end
			end
		end
	end

	assign error_count = mismatches;
	assign pending = pixel_q.size();

	initial mismatches = 0;
endmodule

`default_nettype wire

// ----- dv/tb_optical_flow_color_coder_top.sv -----
// Testbench top of the optical flow color coder: makes flow vector stimulus, drives the APB
// port and the output stall, and gives the verdict. Depends on ofcc_pkg and ofcc_scoreboard.
`default_nettype none

module tb_optical_flow_color_coder_top;

	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT = 5000;
	// Pipeline depth plus margin, waited out before register writes and at the end.
	localparam int DRAIN_CYCLES = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ofcc_pkg::flow_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ofcc_pkg::pix_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int error_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	logic [ofcc_pkg::RADIUS_W-1:0] radius_now;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	optical_flow_color_coder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ofcc_scoreboard u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.error_count(error_count), .pending(pending)
	);

	// The receiver stalls at random with the percentage of the current phase.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: any transaction on either channel or the APB port resets the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// One input transaction; a random gap may come first. The payload is held until
	// the edge at which in_ready is seen high.
	task automatic send_flow(input ofcc_pkg::flow_in_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_vec(input int fx, input int fy, input logic ok);
		ofcc_pkg::flow_in_t item;
		item.flow_x = fx[ofcc_pkg::FLOW_BITS-1:0];
		item.flow_y = fy[ofcc_pkg::FLOW_BITS-1:0];
		item.flow_valid = ok;
		send_flow(item);
	endtask

	// Drain the pipeline, then write max_radius over APB with a setup phase and an access phase.
	task automatic set_radius(input logic [ofcc_pkg::RADIUS_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {ofcc_pkg::REG_MAX_RADIUS, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		radius_now = value;
	endtask

	// A random component: full range, a width chosen at random, or scaled near the radius
	// so that both the desaturated and the scaled branch are hit often.
	function automatic int rand_component(input logic [ofcc_pkg::RADIUS_W-1:0] radius);
		int v;
		int w;
		case ($urandom_range(0, 3))
			0: v = int'($urandom);
			1: begin
				w = $urandom_range(0, ofcc_pkg::FLOW_BITS - 1);
				v = int'($urandom & ((32'd1 << w) - 1));
			end
			default: v = int'($urandom_range(0, 2 * radius + 2));
		endcase
		v = v & ((1 << (ofcc_pkg::FLOW_BITS - 1)) - 1);
		if ($urandom_range(0, 1))
			v = -v - ($urandom_range(0, 7) == 0 ? 1 : 0);
		return v;
	endfunction

	task automatic send_random(input int count);
		int fx;
		int fy;
		for (int n = 0; n < count; n++) begin
			fx = rand_component(radius_now);
			fy = rand_component(radius_now);
			// Axis-aligned vectors now and then, to land on wheel entry boundaries.
			case ($urandom_range(0, 9))
				0: fy = 0;
				1: fx = 0;
				default: ;
			endcase
			send_vec(fx, fy, $urandom_range(0, 7) != 0);
		end
	endtask

	initial begin
		logic [ofcc_pkg::RADIUS_W-1:0] radii [6];
		int max_pos;
		int max_neg;
		max_pos = (1 << (ofcc_pkg::FLOW_BITS - 1)) - 1;
		max_neg = -(1 << (ofcc_pkg::FLOW_BITS - 1));
		send_idle_pct = 21;
		recv_idle_pct = 63;
		radius_now = ofcc_pkg::MAX_RADIUS_RST;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed vectors at the reset radius of 256 (1.0 in Q15.8).
		send_vec(0, 0, 1'b1);               // zero vector: white
		send_vec(max_pos, max_neg, 1'b0);   // invalid vector: black
		send_vec(max_neg, max_pos, 1'b0);
		send_vec(100, 0, 1'b1);             // exactly along +x: wheel entry zero
		send_vec(-100, 0, 1'b1);
		send_vec(0, 100, 1'b1);
		send_vec(0, -100, 1'b1);
		send_vec(256, 0, 1'b1);             // length exactly the radius
		send_vec(257, 0, 1'b1);             // just outside
		send_vec(181, 181, 1'b1);
		send_vec(max_pos, max_pos, 1'b1);
		send_vec(max_neg, max_neg, 1'b1);
		send_vec(max_neg, 0, 1'b1);
		send_vec(0, max_neg, 1'b1);
		send_vec(max_pos, max_neg, 1'b1);
		send_vec(max_neg, max_pos, 1'b1);
		send_vec(1, 1, 1'b1);
		send_vec(-1, 0, 1'b1);
		send_vec(0, -1, 1'b1);
		send_vec(3, -4, 1'b1);
		send_vec(-200, -50, 1'b1);

		// Radius settings: smallest, largest, zero (acts as one), then random ones.
		radii[0] = 23'd1;
		radii[1] = 23'h7FFFFF;
		radii[2] = 23'd0;
		radii[3] = 23'($urandom_range(2, 4096));
		radii[4] = 23'($urandom_range(1, 23'h7FFFFF));
		radii[5] = 23'($urandom_range(64, 1024));
		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle_pct = 63;
				recv_idle_pct = 21;
			end else if (s == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_radius(radii[s]);
			send_random(140);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire
